// ===== design/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, byte codes and the decoder state and result records.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int CP_W          = 21;
    localparam int END_W         = 16;
    localparam int LIMIT_W       = 16;
    localparam int OFFSET_W_DEF  = 16;

    localparam logic [LIMIT_W-1:0] MAX_BYTES_RST = 16'hFFFF;

    // Lead byte boundaries
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] MULTI_MIN = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Continuation byte tag (top two bits)
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Continuation bytes still expected after each lead kind
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_3    = 2'd3;

    typedef struct packed {
        logic [1:0]      pending;
        logic [CP_W-1:0] acc;
        logic            bad;
        logic            stopped;
    } utf8sd_state_t;

    typedef struct packed {
        logic             symbol_done;
        logic [CP_W-1:0]  codepoint;
        logic [END_W-1:0] end_offset;
        logic             within_limit;
        logic             malformed;
        logic             is_last;
    } utf8sd_result_t;

    // Pad an open run with zero bits for the continuation bytes still missing
    function automatic logic [CP_W-1:0] pad_run(input logic [CP_W-1:0] acc,
                                                 input logic [1:0] pending);
        logic [CP_W-1:0] r;
        r = acc;
        case (pending)
            PEND_ONE: r = {acc[CP_W-7:0], 6'b0};
            PEND_TWO: r = {acc[CP_W-13:0], 12'b0};
            PEND_3:   r = {acc[CP_W-19:0], 18'b0};
            default:  r = acc;
        endcase
        return r;
    endfunction

endpackage

// ===== design/utf8_stream_decoder_top.sv =====
// Path: an accepted request waits in the input register and is decoded out of it
//   into the result register, which drives the m_ side.
// Throughput: one byte per cycle while m_ready keeps up; the decode and state
//   update per byte fit in one pass between the input and result registers.
// Reset: aresetn is synchronous, active low; it empties both registers, clears
//   the decoder state and sets max_bytes to 65535.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder top level
// Byte-at-a-time UTF-8 decoder with sticky malformed flag and offset limit.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
    import utf8sd_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_W_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    // byte requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    input  logic               s_last,
    // result requests
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_symbol_done,
    output logic [CP_W-1:0]    m_codepoint,
    output logic [END_W-1:0]   m_end_offset,
    output logic               m_within_limit,
    output logic               m_malformed,
    output logic               m_is_last
);

    // Byte limit register
    logic [LIMIT_W-1:0] max_bytes_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Decoder state
    utf8sd_state_t           state_reg;
    utf8sd_state_t           state_next;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [OFFSET_WIDTH-1:0] offset_next;

    // Result register
    logic           out_valid_reg;
    utf8sd_result_t result_reg;
    utf8sd_result_t result_next;

    logic advance;

    // Advance the byte in the input register when the result slot is free
    // or is being taken this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Accept a new request when the input register empties or is advancing.
    assign s_ready = !in_valid_reg || advance;

    utf8sd_step #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .state       (state_reg),
        .offset      (offset_reg),
        .max_bytes   (max_bytes_reg),
        .byte_in     (byte_reg),
        .last        (last_reg),
        .state_next  (state_next),
        .offset_next (offset_next),
        .result      (result_next)
    );

    // Configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RST;
        end else if (cfg_we) begin
            max_bytes_reg <= cfg_wdata;
        end
    end

    // Input register: hold the request until it advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
            last_reg <= s_last;
        end
    end

    // Decoder state: update only when a byte advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= '0;
            offset_reg <= '0;
        end else if (advance) begin
            state_reg  <= state_next;
            offset_reg <= offset_next;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_symbol_done  = result_reg.symbol_done;
    assign m_codepoint    = result_reg.codepoint;
    assign m_end_offset   = result_reg.end_offset;
    assign m_within_limit = result_reg.within_limit;
    assign m_malformed    = result_reg.malformed;
    assign m_is_last      = result_reg.is_last;

`ifndef SYNTH
    // A stopped string never keeps a run open
    a_stopped_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.stopped |-> state_reg.pending == PEND_NONE)
        else $error("stopped with open run");

    // A result without a completed code point carries a zero code point
    a_cp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_symbol_done) |-> m_codepoint == '0)
        else $error("code point without symbol_done");

    // The last byte of a string returns the decoder state to reset
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=>
            (state_reg == '0 && offset_reg == '0))
        else $error("state not cleared after last byte");

    // An empty result slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result slot");
`endif

endmodule

// ===== design/utf8sd_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder step logic
// Combinational next state and result for one byte of the string.
// ----------------------------------------------------------------------------
module utf8sd_step
    import utf8sd_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_W_DEF
) (
    input  utf8sd_state_t            state,
    input  logic [OFFSET_WIDTH-1:0]  offset,
    input  logic [LIMIT_W-1:0]       max_bytes,
    input  logic [7:0]               byte_in,
    input  logic                     last,
    output utf8sd_state_t            state_next,
    output logic [OFFSET_WIDTH-1:0]  offset_next,
    output utf8sd_result_t           result
);

    localparam int CMP_W = (OFFSET_WIDTH > LIMIT_W) ? OFFSET_WIDTH : LIMIT_W;
    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    utf8sd_state_t           st;
    logic [OFFSET_WIDTH-1:0] off;
    logic                    done;
    logic [CP_W-1:0]         cp;
    logic [CP_W-1:0]         acc_shift;
    logic [1:0]              pend_dec;

    always_comb begin
        st        = state;
        off       = offset;
        done      = 1'b0;
        cp        = '0;
        acc_shift = {state.acc[CP_W-7:0], byte_in[5:0]};
        pend_dec  = 2'(state.pending - 2'd1);

        if (!state.stopped) begin
            if (byte_in == ZERO_BYTE) begin
                // Zero byte: close any open run and stop
                if (state.pending != PEND_NONE) begin
                    st.bad     = 1'b1;
                    cp         = pad_run(state.acc, state.pending);
                    done       = 1'b1;
                    st.pending = PEND_NONE;
                    st.acc     = '0;
                end
                st.stopped = 1'b1;
            end else begin
                if (offset != OFFSET_MAX) begin
                    off = OFFSET_WIDTH'(offset + 1'b1);
                end
                if (state.pending == PEND_NONE) begin
                    if (byte_in < MULTI_MIN) begin
                        cp   = CP_W'(byte_in);
                        done = 1'b1;
                    end else if (byte_in >= LEAD4_MIN) begin
                        st.acc     = CP_W'(byte_in[2:0]);
                        st.pending = PEND_3;
                    end else if (byte_in >= LEAD3_MIN) begin
                        st.acc     = CP_W'(byte_in[3:0]);
                        st.pending = PEND_TWO;
                    end else begin
                        st.acc     = CP_W'(byte_in[4:0]);
                        st.pending = PEND_ONE;
                    end
                end else begin
                    if (byte_in[7:6] != CONT_TAG) begin
                        st.bad = 1'b1;
                    end
                    st.pending = pend_dec;
                    if (pend_dec == PEND_NONE) begin
                        cp     = acc_shift;
                        done   = 1'b1;
                        st.acc = '0;
                    end else begin
                        st.acc = acc_shift;
                    end
                end
                // Run cut short by the end of the string
                if (last && st.pending != PEND_NONE) begin
                    st.bad     = 1'b1;
                    cp         = pad_run(st.acc, st.pending);
                    done       = 1'b1;
                    st.pending = PEND_NONE;
                    st.acc     = '0;
                end
            end
        end

        result.symbol_done  = done;
        result.codepoint    = cp;
        result.end_offset   = END_W'(off);
        result.within_limit = (CMP_W'(off) <= CMP_W'(max_bytes));
        result.malformed    = st.bad;
        result.is_last      = last;

        // End of string: drop all string state
        if (last) begin
            state_next  = '0;
            offset_next = '0;
        end else begin
            state_next  = st;
            offset_next = off;
        end
    end

endmodule

// ===== tb/utf8_stream_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte strings through the decoder and checks every result against a
// cycle-free decoder model kept in the bench. The run covers directed corner
// strings, several byte limits, a long back-pressure hold and a long run of
// mostly well-formed random strings with some noise.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;
    import utf8sd_pkg::*;

    localparam int OFFSET_WIDTH = OFFSET_W_DEF;
    // Cycles with no request moving in either direction before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 80;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in = '0;
    logic               s_last    = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_symbol_done;
    logic [CP_W-1:0]    m_codepoint;
    logic [END_W-1:0]   m_end_offset;
    logic               m_within_limit;
    logic               m_malformed;
    logic               m_is_last;

    // Decoder model state, mirrors what the block keeps for the open string
    logic [1:0]              dec_pending = PEND_NONE;
    logic [CP_W-1:0]         dec_acc     = '0;
    logic [OFFSET_WIDTH-1:0] dec_offset  = '0;
    logic                    dec_bad     = 1'b0;
    logic                    dec_stopped = 1'b0;
    logic [LIMIT_W-1:0]      limit_q     = MAX_BYTES_RST;

    // Results still owed by the block, oldest first
    utf8sd_result_t decoded_fifo[$];
    // Bytes of the next string to send; the last one carries the last mark
    logic [7:0]     str_bytes[$];

    int  n_err       = 0;
    int  bytes_sent  = 0;
    int  idle_cycles = 0;
    int  rx_hold_len = 0;
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;

    utf8_stream_decoder_top #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol_done (m_symbol_done),
        .m_codepoint   (m_codepoint),
        .m_end_offset  (m_end_offset),
        .m_within_limit(m_within_limit),
        .m_malformed   (m_malformed),
        .m_is_last     (m_is_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Decoder model: advance the string state by one accepted byte and return
    // the result the block owes for it.
    // ------------------------------------------------------------------------
    function automatic utf8sd_result_t decode_byte(input logic [7:0] b, input logic lst);
        utf8sd_result_t r;
        logic           cut;
        r   = '0;
        cut = 1'b0;
        if (!dec_stopped) begin
            if (b == ZERO_BYTE) begin
                // A zero byte is not consumed; it closes any open run and
                // freezes the string until the last mark.
                cut         = (dec_pending != PEND_NONE);
                dec_stopped = 1'b1;
            end else begin
                if (dec_offset != '1)
                    dec_offset = dec_offset + 1'b1;
                if (dec_pending == PEND_NONE) begin
                    if (b < MULTI_MIN) begin
                        r.symbol_done = 1'b1;
                        r.codepoint   = CP_W'(b);
                    end else if (b >= LEAD4_MIN) begin
                        dec_acc     = CP_W'(b[2:0]);
                        dec_pending = PEND_3;
                    end else if (b >= LEAD3_MIN) begin
                        dec_acc     = CP_W'(b[3:0]);
                        dec_pending = PEND_TWO;
                    end else begin
                        // Every other high byte, stray continuations too, opens a 2-byte run
                        dec_acc     = CP_W'(b[4:0]);
                        dec_pending = PEND_ONE;
                    end
                end else begin
                    if (b[7:6] != CONT_TAG)
                        dec_bad = 1'b1;
                    dec_acc     = {dec_acc[CP_W-7:0], b[5:0]};
                    dec_pending = dec_pending - 1'b1;
                    if (dec_pending == PEND_NONE) begin
                        r.symbol_done = 1'b1;
                        r.codepoint   = dec_acc;
                        dec_acc       = '0;
                    end
                end
                cut = lst && (dec_pending != PEND_NONE);
            end
            if (cut) begin
                // Pad the open run with zero bits and complete it
                dec_bad       = 1'b1;
                r.symbol_done = 1'b1;
                r.codepoint   = dec_acc << (6 * dec_pending);
                dec_pending   = PEND_NONE;
                dec_acc       = '0;
            end
        end
        r.end_offset   = END_W'(dec_offset);
        r.within_limit = (dec_offset <= limit_q);
        r.malformed    = dec_bad;
        r.is_last      = lst;
        if (lst) begin
            dec_pending = PEND_NONE;
            dec_acc     = '0;
            dec_offset  = '0;
            dec_bad     = 1'b0;
            dec_stopped = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one byte request, optionally after a random gap, and hold
    // it until accepted. Valid stays high into the next call when no gap is
    // drawn, so back-to-back requests never drop valid.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        s_last    <= lst;
        do @(posedge aclk); while (!s_ready);
        decoded_fifo.push_back(decode_byte(b, lst));
        bytes_sent++;
    endtask

    task automatic send_str();
        int i;
        for (i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Stop offering requests and hold until the block owes nothing; then
    // allow the pipeline latency to pass before touching the register.
    task automatic wait_all_decoded();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_fifo.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        limit_q    = v;
    endtask

    // Build a string of well-formed code points with random content. With
    // noise on, corrupt some bytes, drop in zero bytes and sometimes cut the final run.
    task automatic send_random_string(input int n_chars, input bit noisy);
        int         c;
        int         k;
        int         len;
        int         keep;
        logic [7:0] b;
        str_bytes.delete();
        for (c = 0; c < n_chars; c++) begin
            len  = $urandom_range(1, 4);
            keep = len;
            if (noisy && c == n_chars - 1 && $urandom_range(0, 2) == 0)
                keep = $urandom_range(1, len);
            for (k = 0; k < keep; k++) begin
                if (k != 0) begin
                    b = 8'($urandom_range(8'h80, 8'hBF));
                end else begin
                    case (len)
                        1:       b = 8'($urandom_range(8'h01, 8'h7F));
                        2:       b = 8'($urandom_range(8'hC0, 8'hDF));
                        3:       b = 8'($urandom_range(8'hE0, 8'hEF));
                        default: b = 8'($urandom_range(8'hF0, 8'hFF));
                    endcase
                end
                if (noisy && $urandom_range(0, 9) == 0)
                    b = 8'($urandom_range(0, 255));
                if (noisy && $urandom_range(0, 39) == 0)
                    b = ZERO_BYTE;
                str_bytes.push_back(b);
            end
        end
        send_str();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: draw a stall per result; a pending long hold takes priority.
    // ------------------------------------------------------------------------
    initial begin : rx_proc
        int n;
        @(posedge aresetn);
        forever begin
            if (rx_hold_len != 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = rx_idle ? $urandom_range(0, 5) : 0;
            end
            @(negedge aclk);
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endtask

    // Compare each accepted result with the oldest owed one
    always @(posedge aclk) begin : check_proc
        utf8sd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_fifo.size() == 0) begin
                $error("result with none owed: codepoint 0x%0h", m_codepoint);
                n_err++;
            end else begin
                want = decoded_fifo.pop_front();
                check_field("symbol_done", 32'(want.symbol_done), 32'(m_symbol_done));
                check_field("codepoint", 32'(want.codepoint), 32'(m_codepoint));
                check_field("end_offset", 32'(want.end_offset), 32'(m_end_offset));
                check_field("within_limit", 32'(want.within_limit),
                            32'(m_within_limit));
                check_field("malformed", 32'(want.malformed), 32'(m_malformed));
                check_field("is_last", 32'(want.is_last), 32'(m_is_last));
            end
        end
    end

    // Watchdog: abandon the run when no request moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("utf8_stream_decoder_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner strings, run with the byte limit still at its reset value
    task automatic test_directed();
        // ASCII extremes, 2/3/4-byte runs, largest code point
        str_bytes = '{8'h01, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                      8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_str();
        // Bad continuation, stray 0x80 as lead, 0xFF lead cut short by last
        str_bytes = '{8'hC3, 8'h41, 8'h80, 8'hFF, 8'hFF, 8'hBF};
        send_str();
        // Zero byte inside a run: pad, complete, then ignore up to last
        str_bytes = '{8'hE2, 8'h00, 8'h41, 8'h00};
        send_str();
        // Zero byte with no run open, then an ignored last byte
        str_bytes = '{8'h00, 8'h7F};
        send_str();
        // Lead byte that is itself the last byte
        str_bytes = '{8'h80};
        send_str();
    endtask

    task automatic test_limit_extremes();
        wait_all_decoded();
        set_limit(16'h0000);
        // Offset zero still fits a zero limit
        str_bytes = '{8'h00, 8'h41};
        send_str();
        send_random_string(3, 1'b0);
        wait_all_decoded();
        set_limit(16'd3);
        send_random_string(4, 1'b0);
        wait_all_decoded();
        set_limit(16'hAAAA);
        send_random_string(2, 1'b0);
        wait_all_decoded();
        set_limit(16'h5555);
        send_random_string(2, 1'b1);
    endtask

    // Hold the receiver off while requests keep coming, so the block fills
    // and drops s_ready; then release and drain.
    task automatic test_backpressure();
        wait_all_decoded();
        set_limit(LIMIT_W'($urandom_range(0, 20)));
        tx_idle     = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        send_random_string(8, 1'b0);
        send_random_string(6, 1'b1);
        tx_idle = 1'b1;
        wait_all_decoded();
    endtask

    // Phases of random strings, each under a fresh limit and idling mix
    task automatic test_random_strings();
        int target;
        int phase;
        target = bytes_sent + RANDOM_BYTES;
        phase  = 0;
        while (bytes_sent < target) begin
            wait_all_decoded();
            case (phase % 5)
                0:       set_limit(16'h0000);
                1:       set_limit(16'hFFFF);
                2:       set_limit(LIMIT_W'($urandom_range(0, 16'hFFFF)));
                default: set_limit(LIMIT_W'($urandom_range(0, 40)));
            endcase
            tx_idle = (phase % 3 != 2);
            rx_idle = (phase % 4 != 3);
            repeat (6) send_random_string($urandom_range(1, 8), $urandom_range(0, 3) == 0);
            phase++;
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_limit_extremes();
        test_backpressure();
        test_random_strings();
        wait_all_decoded();
        repeat (8) @(posedge aclk);
        if (n_err == 0)
            $display("utf8_stream_decoder_top: match");
        else
            $display("utf8_stream_decoder_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/utf8sd_pkg.sv
design/utf8sd_step.sv
design/utf8_stream_decoder_top.sv
tb/utf8_stream_decoder_top_tb.sv
